// ===== hdl/bfhp_pkg.sv =====
// ============================================================================
// bfhp_pkg
// Shared types and constants for the bitstream file header parser: parse
// phases, byte classification, queue entries and result codes.
// ============================================================================
`default_nettype none

package bfhp_pkg;

    // parse phases of the tagged file walk
    typedef enum logic [3:0] {
        PH_HLEN_HI,
        PH_HLEN_LO,
        PH_HSKIP,
        PH_SLEN_HI,
        PH_SLEN_LO,
        PH_TAG,
        PH_FLEN_HI,
        PH_FLEN_LO,
        PH_FIELD,
        PH_PLEN0,
        PH_PLEN1,
        PH_PLEN2,
        PH_PLEN3,
        PH_PAYLOAD,
        PH_TRAIL,
        PH_DEAD
    } t_phase;

    // flags worked out by the front end for one byte
    typedef struct packed {
        logic       is_e;
        logic       is_meta;
        logic [1:0] meta_idx;
        logic [3:0] sync_hit;
        logic       is_ff;
    } t_class;

    // one entry of the queue between front and back
    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
        logic       raw;
        t_class     cls;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic [1:0] byte_kind;
        logic [1:0] field_tag;
        logic [7:0] byte_out;
        logic       finished;
        logic [2:0] status_code;
    } t_result;

    // byte kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_META    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_TRAIL   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_BAD_SLEN   = 3'd2;
    localparam logic [2:0] ST_TRUNCATED  = 3'd3;
    localparam logic [2:0] ST_PAY_SHORT  = 3'd4;
    localparam logic [2:0] ST_NO_PAYLOAD = 3'd5;
    localparam logic [2:0] ST_NO_SYNC    = 3'd6;
    localparam logic [2:0] ST_BLANK      = 3'd7;

    // tag bytes and the code for a tag that is not metadata
    localparam logic [7:0] CHAR_A    = 8'h61;
    localparam logic [7:0] CHAR_D    = 8'h64;
    localparam logic [7:0] CHAR_E    = 8'h65;
    localparam logic [2:0] TAG_OTHER = 3'd4;

    // sync word and blank byte
    localparam logic [7:0] SYNC_B0    = 8'haa;
    localparam logic [7:0] SYNC_B1    = 8'h99;
    localparam logic [7:0] SYNC_B2    = 8'h55;
    localparam logic [7:0] SYNC_B3    = 8'h66;
    localparam logic [7:0] BLANK_BYTE = 8'hff;

    // input format register
    localparam logic FORMAT_RAW   = 1'b0;
    localparam logic FORMAT_RESET = 1'b1;

    // depth of both queues
    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== hdl/bitstream_file_header_parser_unit.sv =====
// A byte passes through the item queue and then the result queue before its result reaches the ports.
// Throughput: one byte per cycle while neither queue is full; the parser updates its state once per byte.
// A two-entry queue sits between front and parser and another before the result side.
// Reset (synchronous, active low) empties both queues, clears the parse state
// and sets the input format to tagged bit file. There is no clearing pass.
// ============================================================================
// bitstream_file_header_parser_unit
// Top level: byte classifier, queue, parser and result queue.
// ============================================================================
`default_nettype none

module bitstream_file_header_parser_unit #(
    parameter int SYNC_WINDOW    = 4096,
    parameter int MIN_FILE_BYTES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_input_format,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_is_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      o_byte_kind,
    output logic [1:0]      o_field_tag,
    output logic [7:0]      o_byte_out,
    output logic            o_finished,
    output logic [2:0]      o_status_code
);

    import bfhp_pkg::*;

    t_item   front_item;
    t_item   back_item;
    t_result back_result;
    t_result out_result;
    logic    q_wr;
    logic    q_empty;
    logic    back_take;
    logic    res_full;

    // front end
    bfhp_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_input_format (i_cfg_input_format),
        .i_push             (push),
        .i_q_full           (full),
        .i_byte_value       (i_byte_value),
        .i_is_last          (i_is_last),
        .o_q_wr             (q_wr),
        .o_item             (front_item)
    );

    // queue between front and back
    bfhp_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (front_item),
        .i_rd    (back_take),
        .o_rdata (back_item),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // parser
    bfhp_back #(
        .SYNC_WINDOW    (SYNC_WINDOW),
        .MIN_FILE_BYTES (MIN_FILE_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!q_empty),
        .i_item     (back_item),
        .i_res_full (res_full),
        .o_take     (back_take),
        .o_result   (back_result)
    );

    // result queue
    bfhp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (back_take),
        .i_wdata (back_result),
        .i_rd    (pop),
        .o_rdata (out_result),
        .o_full  (res_full),
        .o_empty (empty)
    );

    // result ports
    assign o_byte_kind   = out_result.byte_kind;
    assign o_field_tag   = out_result.field_tag;
    assign o_byte_out    = out_result.byte_out;
    assign o_finished    = out_result.finished;
    assign o_status_code = out_result.status_code;

endmodule

`default_nettype wire

// ===== hdl/bfhp_fifo.sv =====
// ============================================================================
// bfhp_fifo
// Small register queue used between front and back and in front of the
// result ports. Read data is taken from the oldest entry.
// ============================================================================
`default_nettype none

module bfhp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_ok;
    logic             rd_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_ok) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bfhp_front.sv =====
// ============================================================================
// bfhp_front
// Input side: holds the format register, accepts bytes and tags each one
// with the compare results the parser needs.
// ============================================================================
`default_nettype none

module bfhp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_input_format,
    input  wire logic           i_push,
    input  wire logic           i_q_full,
    input  wire logic [7:0]     i_byte_value,
    input  wire logic           i_is_last,
    output logic                o_q_wr,
    output bfhp_pkg::t_item     o_item
);

    import bfhp_pkg::*;

    logic       r_format;
    logic [1:0] meta_off;

    // format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FORMAT_RESET;
        end else if (i_cfg_we) begin
            r_format <= i_cfg_input_format;
        end
    end

    // byte classification, tag index only needs the low two bits
    assign meta_off = i_byte_value[1:0] - CHAR_A[1:0];

    always_comb begin
        o_item.byte_value   = i_byte_value;
        o_item.is_last      = i_is_last;
        o_item.raw          = (r_format == FORMAT_RAW);
        o_item.cls.is_e     = (i_byte_value == CHAR_E);
        o_item.cls.is_meta  = (i_byte_value >= CHAR_A) && (i_byte_value <= CHAR_D);
        o_item.cls.meta_idx = meta_off;
        o_item.cls.sync_hit = {i_byte_value == SYNC_B3, i_byte_value == SYNC_B2,
                               i_byte_value == SYNC_B1, i_byte_value == SYNC_B0};
        o_item.cls.is_ff    = (i_byte_value == BLANK_BYTE);
    end

    // queue write on each accepted transaction
    assign o_q_wr = i_push && !i_q_full;

endmodule

`default_nettype wire

// ===== hdl/bfhp_back.sv =====
// ============================================================================
// bfhp_back
// Parser state machine: walks header, tagged fields and payload, tracks
// the sync word and blank check, and forms one result per byte.
// ============================================================================
`default_nettype none

module bfhp_back #(
    parameter int SYNC_WINDOW    = 4096,
    parameter int MIN_FILE_BYTES = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire bfhp_pkg::t_item i_item,
    input  wire logic            i_res_full,
    output logic                 o_take,
    output bfhp_pkg::t_result    o_result
);

    import bfhp_pkg::*;

    localparam int SW_W = $clog2(SYNC_WINDOW + 1);
    localparam int FC_W = $clog2(MIN_FILE_BYTES + 1);

    t_phase      r_phase,     n_phase;
    logic [31:0] r_remain,    n_remain;
    logic [FC_W-1:0] r_fcount, n_fcount;
    logic [SW_W-1:0] r_sync_cnt, n_sync_cnt;
    logic [1:0]  r_sync_prog, n_sync_prog;
    logic        r_sync_seen, n_sync_seen;
    logic        r_not_blank, n_not_blank;
    logic [2:0]  r_tag,       n_tag;
    logic [2:0]  r_err,       n_err;
    logic        feed;
    logic [2:0]  pay_status;

    assign o_take = i_valid && !i_res_full;

    // next state and parse datapath
    always_comb begin
        n_phase     = r_phase;
        n_remain    = r_remain;
        n_tag       = r_tag;
        n_err       = r_err;
        n_sync_cnt  = r_sync_cnt;
        n_sync_prog = r_sync_prog;
        n_sync_seen = r_sync_seen;
        n_not_blank = r_not_blank;
        n_fcount    = (r_fcount < FC_W'(MIN_FILE_BYTES)) ? r_fcount + 1'b1 : r_fcount;
        feed        = i_item.raw || (r_phase == PH_PAYLOAD);

        // payload checks
        if (feed) begin
            if (!i_item.cls.is_ff) begin
                n_not_blank = 1'b1;
            end
            if (r_sync_cnt < SW_W'(SYNC_WINDOW)) begin
                n_sync_cnt = r_sync_cnt + 1'b1;
                if (!r_sync_seen) begin
                    if (i_item.cls.sync_hit[r_sync_prog]) begin
                        if (r_sync_prog == 2'd3) begin
                            n_sync_seen = 1'b1;
                            n_sync_prog = 2'd0;
                        end else begin
                            n_sync_prog = r_sync_prog + 1'b1;
                        end
                    end else begin
                        n_sync_prog = i_item.cls.sync_hit[0] ? 2'd1 : 2'd0;
                    end
                end
            end
        end

        // tagged file walk
        if (!i_item.raw) begin
            case (r_phase)
                PH_HLEN_HI, PH_SLEN_HI, PH_FLEN_HI: begin
                    n_remain = {16'd0, i_item.byte_value, 8'd0};
                    n_phase  = t_phase'(r_phase + 1'b1);
                end
                PH_HLEN_LO: begin
                    n_remain = {16'd0, r_remain[15:8], i_item.byte_value};
                    n_phase  = (n_remain != '0) ? PH_HSKIP : PH_SLEN_HI;
                end
                PH_HSKIP: begin
                    n_remain = r_remain - 1'b1;
                    if (r_remain == 32'd1) begin
                        n_phase = PH_SLEN_HI;
                    end
                end
                PH_SLEN_LO: begin
                    if ({r_remain[15:8], i_item.byte_value} != 16'd1) begin
                        n_err   = ST_BAD_SLEN;
                        n_phase = PH_DEAD;
                    end else begin
                        n_phase = PH_TAG;
                    end
                    n_remain = '0;
                end
                PH_TAG: begin
                    if (i_item.cls.is_e) begin
                        n_remain = '0;
                        n_phase  = PH_PLEN0;
                    end else begin
                        n_tag   = i_item.cls.is_meta ? {1'b0, i_item.cls.meta_idx}
                                                     : TAG_OTHER;
                        n_phase = PH_FLEN_HI;
                    end
                end
                PH_FLEN_LO: begin
                    n_remain = {16'd0, r_remain[15:8], i_item.byte_value};
                    n_phase  = (n_remain != '0) ? PH_FIELD : PH_TAG;
                end
                PH_FIELD: begin
                    n_remain = r_remain - 1'b1;
                    if (r_remain == 32'd1) begin
                        n_phase = PH_TAG;
                    end
                end
                PH_PLEN0, PH_PLEN1, PH_PLEN2: begin
                    n_remain = {r_remain[23:0], i_item.byte_value};
                    n_phase  = t_phase'(r_phase + 1'b1);
                end
                PH_PLEN3: begin
                    n_remain = {r_remain[23:0], i_item.byte_value};
                    n_phase  = (n_remain != '0) ? PH_PAYLOAD : PH_TRAIL;
                end
                PH_PAYLOAD: begin
                    n_remain = r_remain - 1'b1;
                    if (r_remain == 32'd1) begin
                        n_phase = PH_TRAIL;
                    end
                end
                PH_TRAIL, PH_DEAD: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // result fields
    always_comb begin
        o_result.byte_out  = i_item.byte_value;
        o_result.finished  = i_item.is_last;
        o_result.field_tag = 2'd0;
        o_result.byte_kind = KIND_HEADER;
        if (i_item.raw) begin
            o_result.byte_kind = KIND_PAYLOAD;
        end else begin
            case (r_phase)
                PH_FIELD: begin
                    if (r_tag != TAG_OTHER) begin
                        o_result.byte_kind = KIND_META;
                        o_result.field_tag = r_tag[1:0];
                    end
                end
                PH_PAYLOAD: o_result.byte_kind = KIND_PAYLOAD;
                PH_TRAIL:   o_result.byte_kind = KIND_TRAIL;
                default:    o_result.byte_kind = KIND_HEADER;
            endcase
        end

        // end of file status
        pay_status = !n_sync_seen ? ST_NO_SYNC : (!n_not_blank ? ST_BLANK : ST_OK);
        o_result.status_code = ST_OK;
        if (i_item.is_last) begin
            if (i_item.raw) begin
                o_result.status_code = pay_status;
            end else if (n_fcount < FC_W'(MIN_FILE_BYTES)) begin
                o_result.status_code = ST_TOO_SHORT;
            end else if (n_err != ST_OK) begin
                o_result.status_code = n_err;
            end else begin
                case (n_phase)
                    PH_TAG:     o_result.status_code = ST_NO_PAYLOAD;
                    PH_PAYLOAD: o_result.status_code = ST_PAY_SHORT;
                    PH_TRAIL:   o_result.status_code = pay_status;
                    default:    o_result.status_code = ST_TRUNCATED;
                endcase
            end
        end
    end

    // parse state, cleared after the last byte of a file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_item.is_last)) begin
            r_phase     <= PH_HLEN_HI;
            r_remain    <= '0;
            r_fcount    <= '0;
            r_sync_cnt  <= '0;
            r_sync_prog <= '0;
            r_sync_seen <= 1'b0;
            r_not_blank <= 1'b0;
            r_tag       <= '0;
            r_err       <= ST_OK;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_remain    <= n_remain;
            r_fcount    <= n_fcount;
            r_sync_cnt  <= n_sync_cnt;
            r_sync_prog <= n_sync_prog;
            r_sync_seen <= n_sync_seen;
            r_not_blank <= n_not_blank;
            r_tag       <= n_tag;
            r_err       <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bfhp_checker.sv =====
// ============================================================================
// bfhp_checker
// Port-level checks on the result side of the parser, bound to the top.
// ============================================================================
`default_nettype none

module bfhp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [1:0] o_byte_kind,
    input wire logic [1:0] o_field_tag,
    input wire logic [7:0] o_byte_out,
    input wire logic       o_finished,
    input wire logic [2:0] o_status_code
);

    import bfhp_pkg::*;

    // the result queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    // a status only comes with the last byte of a file
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_finished) |-> (o_status_code == ST_OK))
        else $error("status reported on a byte that is not last");

    // tag is only set on metadata bytes
    a_tag_meta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_kind != KIND_META) |-> (o_field_tag == 2'd0))
        else $error("field tag set outside metadata");

    // a payload with the sync word is never blank
    a_no_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status_code != ST_BLANK))
        else $error("blank status reported");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_byte_out) && $stable(o_finished)))
        else $error("waiting result changed");

endmodule

bind bitstream_file_header_parser_unit bfhp_checker u_bfhp_checker (.*);

`default_nettype wire
